### rtl/core/vpcu_pkg.sv
// Shared types, constants and neighbor tables of the pixel classify/update block.
package vpcu_pkg;

    localparam int SAMPLES_PER_PIXEL_DEF = 10;
    localparam int FRAME_WIDTH_DEF       = 320;
    localparam int FRAME_HEIGHT_DEF      = 240;

    localparam int PIX_W   = 8;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 9;
    localparam int SLOT_W  = 4;
    localparam int CODE_W  = 6;
    localparam int RAD_W   = 8;
    localparam int MIN_W   = 4;
    localparam int REACH_W = 2;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [RAD_W-1:0]   RADIUS_RST = 8'd20;
    localparam logic [MIN_W-1:0]   MIN_RST    = 4'd2;
    localparam logic [REACH_W-1:0] REACH_RST  = 2'd1;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_LOAD     = 1'b1;

    localparam int RING_CODES = 48;
    localparam int OFS_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_RADIUS   = 2'd0,
        CFG_MIN_MATCHES    = 2'd1,
        CFG_NEIGHBOR_REACH = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CMP,
        ST_DEC,
        ST_NBW,
        ST_FIN
    } state_t;

    typedef logic signed [OFS_W-1:0] ofs_t;

    // ring order: 3x3 ring, then 5x5 ring, then 7x7 ring
    localparam ofs_t RING_DR [RING_CODES] = '{
        -3'sd1, -3'sd1, -3'sd1,  3'sd1,  3'sd1,  3'sd1,  3'sd0,  3'sd0,
        -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2,  3'sd2,  3'sd2,  3'sd2,  3'sd2,  3'sd2,
        -3'sd1,  3'sd0,  3'sd1, -3'sd1,  3'sd0,  3'sd1,
        -3'sd3, -3'sd3, -3'sd3, -3'sd3, -3'sd3, -3'sd3, -3'sd3,
         3'sd3,  3'sd3,  3'sd3,  3'sd3,  3'sd3,  3'sd3,  3'sd3,
        -3'sd2, -3'sd1,  3'sd0,  3'sd1,  3'sd2, -3'sd2, -3'sd1,  3'sd0,  3'sd1,  3'sd2
    };

    localparam ofs_t RING_DC [RING_CODES] = '{
        -3'sd1,  3'sd0,  3'sd1, -3'sd1,  3'sd0,  3'sd1, -3'sd1,  3'sd1,
        -3'sd2, -3'sd1,  3'sd0,  3'sd1,  3'sd2, -3'sd2, -3'sd1,  3'sd0,  3'sd1,  3'sd2,
        -3'sd2, -3'sd2, -3'sd2,  3'sd2,  3'sd2,  3'sd2,
        -3'sd3, -3'sd2, -3'sd1,  3'sd0,  3'sd1,  3'sd2,  3'sd3,
        -3'sd3, -3'sd2, -3'sd1,  3'sd0,  3'sd1,  3'sd2,  3'sd3,
        -3'sd3, -3'sd3, -3'sd3, -3'sd3, -3'sd3,  3'sd3,  3'sd3,  3'sd3,  3'sd3,  3'sd3
    };

    // kernel*kernel - 1 with kernel = 2*reach + 1
    function automatic logic [CODE_W-1:0] code_limit(input logic [REACH_W-1:0] reach);
        logic [CODE_W-1:0] lim;
        case (reach)
            2'd1:    lim = 6'd8;
            2'd2:    lim = 6'd24;
            2'd3:    lim = 6'd48;
            default: lim = 6'd0;
        endcase
        return lim;
    endfunction

endpackage

### rtl/core/vpcu_in_if.sv
// Input channel: one pixel item per handshake.
interface vpcu_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [vpcu_pkg::PIX_W-1:0]        pixel_value;
    logic [vpcu_pkg::ROW_W-1:0]        pixel_row;
    logic [vpcu_pkg::COL_W-1:0]        pixel_col;
    logic                              refresh_own;
    logic [vpcu_pkg::SLOT_W-1:0]       own_slot;
    logic                              refresh_neighbor;
    logic [vpcu_pkg::CODE_W-1:0]       neighbor_code;
    logic [vpcu_pkg::SLOT_W-1:0]       neighbor_slot;

    modport source (
        output valid, command, pixel_value, pixel_row, pixel_col, refresh_own,
               own_slot, refresh_neighbor, neighbor_code, neighbor_slot,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_value, pixel_row, pixel_col, refresh_own,
               own_slot, refresh_neighbor, neighbor_code, neighbor_slot,
        output ready
    );
endinterface

### rtl/core/vpcu_out_if.sv
// Output channel: one classification item per handshake.
interface vpcu_out_if;
    logic valid;
    logic ready;
    logic foreground;

    modport source (output valid, foreground, input ready);
    modport sink (input valid, foreground, output ready);
endinterface

### rtl/core/vpcu_ram.sv
// Generic single-port RAM with bit write mask and registered read.
module vpcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wmask,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wmask[i])
                    mem[addr][i] <= wdata[i];
            end
        end
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/vpcu_match.sv
// Sample compare unit: registers per-slot match flags, counts them.
module vpcu_match #(
    parameter int SAMPLES_PER_PIXEL = vpcu_pkg::SAMPLES_PER_PIXEL_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [SAMPLES_PER_PIXEL*8-1:0]       samples,
    input  logic [vpcu_pkg::PIX_W-1:0]           pixel,
    input  logic [vpcu_pkg::RAD_W-1:0]           radius,
    output logic [$clog2(SAMPLES_PER_PIXEL+1)-1:0] count
);

    localparam int CW = $clog2(SAMPLES_PER_PIXEL + 1);

    logic [SAMPLES_PER_PIXEL-1:0] match_reg;
    logic [SAMPLES_PER_PIXEL-1:0] match_next;

    always_comb
    begin
        logic [7:0] s;
        logic [7:0] d;
        for (int k = 0; k < SAMPLES_PER_PIXEL; k++)
        begin
            s = samples[8*k +: 8];
            d = (s >= pixel) ? (s - pixel) : (pixel - s);
            match_next[k] = (d <= radius);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            match_reg <= match_next;
    end

    always_comb
    begin
        count = '0;
        for (int k = 0; k < SAMPLES_PER_PIXEL; k++)
            count = count + CW'(match_reg[k]);
    end

endmodule

### rtl/core/vibe_pixel_classify_update_top.sv
// Top level of the pixel classify/update block: control, config and sample memory.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          command, pixel, row, col, refresh and slot draws
//  out_ch    out  valid/ready          foreground
//  cfg       in   cfg_we (no stall)    cfg_index, cfg_data
//
// One item at a time. Classify: prep, compare, decide, a neighbor write when due,
// then finish; load, border and out-of-frame items: prep, then finish. The single
// sample memory port sets this: one wide row read, then own and neighbor writes.
// Reset clears control and config; sample memory holds garbage until loaded.
// A result held in out_ch does not stop the next item from being accepted; it
// stalls the block only when a second result is ready before the first is taken.
module vibe_pixel_classify_update_top #(
    parameter int SAMPLES_PER_PIXEL = vpcu_pkg::SAMPLES_PER_PIXEL_DEF,
    parameter int FRAME_WIDTH       = vpcu_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT      = vpcu_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vpcu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vpcu_pkg::CFG_W-1:0]      cfg_data,
    vpcu_in_if.sink                         in_ch,
    vpcu_out_if.source                      out_ch
);

    localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW     = $clog2(PIXELS);
    localparam int RW     = SAMPLES_PER_PIXEL * 8;
    localparam int CW     = $clog2(SAMPLES_PER_PIXEL + 1);
    localparam int CMPW   = (CW > vpcu_pkg::MIN_W) ? CW : vpcu_pkg::MIN_W;
    localparam int NW     = 14;

    // config
    logic [vpcu_pkg::RAD_W-1:0]   radius_reg;
    logic [vpcu_pkg::MIN_W-1:0]   min_reg;
    logic [vpcu_pkg::REACH_W-1:0] reach_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= vpcu_pkg::RADIUS_RST;
            min_reg    <= vpcu_pkg::MIN_RST;
            reach_reg  <= vpcu_pkg::REACH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vpcu_pkg::CFG_MATCH_RADIUS:   radius_reg <= cfg_data;
                vpcu_pkg::CFG_MIN_MATCHES:    min_reg    <= cfg_data[vpcu_pkg::MIN_W-1:0];
                vpcu_pkg::CFG_NEIGHBOR_REACH: reach_reg  <= cfg_data[vpcu_pkg::REACH_W-1:0];
                default: ;
            endcase
        end
    end

    // item fields, latched at accept
    logic                             cmd_reg;
    logic [vpcu_pkg::PIX_W-1:0]       pix_reg;
    logic [vpcu_pkg::ROW_W-1:0]       row_reg;
    logic [vpcu_pkg::COL_W-1:0]       col_reg;
    logic                             own_en_reg;
    logic [vpcu_pkg::SLOT_W-1:0]      own_slot_reg;
    logic                             nb_en_reg;
    logic [vpcu_pkg::CODE_W-1:0]      code_reg;
    logic [vpcu_pkg::SLOT_W-1:0]      nb_slot_reg;
    logic [AW-1:0]                    addr_reg;
    logic [AW-1:0]                    nb_addr_reg;
    logic                             nb_ok_reg;
    logic                             item_fg_reg;
    logic                             out_valid_reg;
    logic                             out_fg_reg;

    vpcu_pkg::state_t state_reg, state_next;

    logic accept;
    logic [31:0] own_lin;

    assign accept  = in_ch.valid && in_ch.ready;
    assign own_lin = 32'(in_ch.pixel_row) * 32'(FRAME_WIDTH) + 32'(in_ch.pixel_col);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= in_ch.command;
            pix_reg      <= in_ch.pixel_value;
            row_reg      <= in_ch.pixel_row;
            col_reg      <= in_ch.pixel_col;
            own_en_reg   <= in_ch.refresh_own;
            own_slot_reg <= in_ch.own_slot;
            nb_en_reg    <= in_ch.refresh_neighbor;
            code_reg     <= in_ch.neighbor_code;
            nb_slot_reg  <= in_ch.neighbor_slot;
            addr_reg     <= own_lin[AW-1:0];
        end
    end

    // position checks on the latched item
    logic out_frame;
    logic border;
    logic [31:0] r32;

    assign r32 = 32'(reach_reg);
    assign out_frame = (32'(row_reg) >= 32'(FRAME_HEIGHT)) || (32'(col_reg) >= 32'(FRAME_WIDTH));
    assign border = (32'(row_reg) < r32) || (32'(col_reg) < r32) ||
                    (32'(row_reg) + r32 >= 32'(FRAME_HEIGHT)) ||
                    (32'(col_reg) + r32 >= 32'(FRAME_WIDTH));

    // neighbor address
    logic                        code_in_ring;
    vpcu_pkg::ofs_t              dr;
    vpcu_pkg::ofs_t              dc;
    logic signed [NW-1:0]        nr;
    logic signed [NW-1:0]        nc;
    logic                        nb_in_frame;
    logic                        nb_ok_next;
    logic [31:0]                 nb_lin;

    assign code_in_ring = (code_reg < vpcu_pkg::code_limit(reach_reg)) &&
                          (code_reg < vpcu_pkg::CODE_W'(vpcu_pkg::RING_CODES));
    assign dr = code_in_ring ? vpcu_pkg::RING_DR[code_reg] : '0;
    assign dc = code_in_ring ? vpcu_pkg::RING_DC[code_reg] : '0;
    assign nr = signed'(NW'(row_reg)) + NW'(dr);
    assign nc = signed'(NW'(col_reg)) + NW'(dc);
    assign nb_in_frame = (nr >= 0) && (nc >= 0) &&
                         (nr < signed'(NW'(FRAME_HEIGHT))) && (nc < signed'(NW'(FRAME_WIDTH)));
    assign nb_ok_next = nb_en_reg && (32'(nb_slot_reg) < 32'(SAMPLES_PER_PIXEL)) &&
                        (reach_reg != '0) && code_in_ring && nb_in_frame;
    assign nb_lin = 32'(nr[NW-2:0]) * 32'(FRAME_WIDTH) + 32'(nc[NW-2:0]);

    // memory and compare
    logic          ram_re;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [RW-1:0] ram_wmask;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;
    logic [CW-1:0] match_count;
    logic          background;
    logic          own_ok;
    logic [RW-1:0] own_mask;
    logic [RW-1:0] nb_mask;

    vpcu_ram #(
        .WIDTH (RW),
        .DEPTH (PIXELS)
    ) u_ram (
        .clk   (clk),
        .re    (ram_re),
        .we    (ram_we),
        .addr  (ram_addr),
        .wmask (ram_wmask),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vpcu_match #(
        .SAMPLES_PER_PIXEL (SAMPLES_PER_PIXEL)
    ) u_match (
        .clk     (clk),
        .en      (state_reg == vpcu_pkg::ST_CMP),
        .samples (ram_rdata),
        .pixel   (pix_reg),
        .radius  (radius_reg),
        .count   (match_count)
    );

    // early stop of the slot scan does not change the verdict: total count decides
    assign background = CMPW'(match_count) >= CMPW'(min_reg);
    assign own_ok = own_en_reg && (32'(own_slot_reg) < 32'(SAMPLES_PER_PIXEL));
    assign ram_wdata = {SAMPLES_PER_PIXEL{pix_reg}};

    always_comb
    begin
        for (int k = 0; k < SAMPLES_PER_PIXEL; k++)
        begin
            own_mask[8*k +: 8] = {8{32'(own_slot_reg) == k}};
            nb_mask[8*k +: 8]  = {8{32'(nb_slot_reg) == k}};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vpcu_pkg::ST_IDLE:
                if (accept)
                    state_next = vpcu_pkg::ST_PREP;
            vpcu_pkg::ST_PREP:
                if (out_frame || cmd_reg == vpcu_pkg::CMD_LOAD || border)
                    state_next = vpcu_pkg::ST_FIN;
                else
                    state_next = vpcu_pkg::ST_CMP;
            vpcu_pkg::ST_CMP:
                state_next = vpcu_pkg::ST_DEC;
            vpcu_pkg::ST_DEC:
                if (background && nb_ok_reg)
                    state_next = vpcu_pkg::ST_NBW;
                else
                    state_next = vpcu_pkg::ST_FIN;
            vpcu_pkg::ST_NBW:
                state_next = vpcu_pkg::ST_FIN;
            vpcu_pkg::ST_FIN:
                if (!out_valid_reg || out_ch.ready)
                    state_next = vpcu_pkg::ST_IDLE;
            default:
                state_next = vpcu_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wmask = '0;
        case (state_reg)
            vpcu_pkg::ST_PREP:
                if (!out_frame)
                begin
                    if (cmd_reg == vpcu_pkg::CMD_LOAD)
                    begin
                        ram_we    = 1'b1;
                        ram_wmask = '1;
                    end
                    else if (!border)
                        ram_re = 1'b1;
                end
            vpcu_pkg::ST_DEC:
                if (background && own_ok)
                begin
                    ram_we    = 1'b1;
                    ram_wmask = own_mask;
                end
            vpcu_pkg::ST_NBW:
            begin
                ram_we    = 1'b1;
                ram_addr  = nb_addr_reg;
                ram_wmask = nb_mask;
            end
            default: ;
        endcase
    end

    assign in_ch.ready       = (state_reg == vpcu_pkg::ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.foreground = out_fg_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == vpcu_pkg::ST_PREP)
        begin
            nb_addr_reg <= nb_lin[AW-1:0];
            nb_ok_reg   <= nb_ok_next;
        end
        if (state_reg == vpcu_pkg::ST_FIN && (!out_valid_reg || out_ch.ready))
            out_fg_reg <= item_fg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vpcu_pkg::ST_IDLE;
            item_fg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vpcu_pkg::ST_PREP)
                item_fg_reg <= 1'b0;
            else if (state_reg == vpcu_pkg::ST_DEC)
                item_fg_reg <= !background;
            if (state_reg == vpcu_pkg::ST_FIN && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && ram_we))
        else $error("sample memory read and write in the same cycle");

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == vpcu_pkg::ST_PREP))
        else $error("accepted item did not enter prep");

    a_nb_write_bg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vpcu_pkg::ST_NBW) |-> (!item_fg_reg && nb_ok_reg))
        else $error("neighbor write for a foreground item");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vpcu_pkg::ST_CMP) |-> $past(ram_re))
        else $error("compare without a preceding row read");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vpcu_pkg::ST_DEC) |-> (32'(match_count) <= 32'(SAMPLES_PER_PIXEL)))
        else $error("match count above sample count");

endmodule
